### rtl/ekn_pkg.sv
// ----------------------------------------------------------------------------
// ekn_pkg
// Shared types, register indexes and codes of the encoder knob selector.
// ----------------------------------------------------------------------------
package ekn_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE_HOLD    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STATION_STEP = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME_STEP  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE       = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLINK        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_STATION_CNT  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_LED_MODE     = 3'd6;

	// encoder step codes
	localparam logic [1:0] STEP_INC = 2'd1;
	localparam logic [1:0] STEP_DEC = 2'd2;

	// LED modes
	localparam logic [3:0] LED_GREEN       = 4'd1;
	localparam logic [3:0] LED_RED         = 4'd2;
	localparam logic [3:0] LED_ORANGE      = 4'd3;
	localparam logic [3:0] LED_GREEN_BLINK = 4'd4;
	localparam logic [3:0] LED_RED_BLINK   = 4'd5;
	localparam logic [3:0] LED_ORANGE_BLNK = 4'd6;
	localparam logic [3:0] LED_G_ON_R_BLNK = 4'd7;
	localparam logic [3:0] LED_R_ON_G_BLNK = 4'd8;

	localparam logic MODE_STATION = 1'b0;
	localparam logic MODE_VOLUME  = 1'b1;

	typedef struct packed {
		logic [15:0] mode_hold_ms;
		logic [15:0] station_step_ms;
		logic [15:0] volume_step_ms;
		logic [15:0] settle_ms;
		logic [15:0] blink_ms;
		logic [8:0]  station_total;
		logic [3:0]  led_mode;
	} cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] now_ms;
		logic                 mode_pressed;
		logic [1:0]           enc_step;
	} item_t;

	typedef struct packed {
		logic       mode_now;
		logic [7:0] station_sel;
		logic [7:0] volume_sel;
		logic       show_station;
		logic       show_volume;
		logic       disconnect_req;
		logic       connect_req;
		logic       volume_apply;
		logic       led_green;
		logic       led_red;
	} res_t;

endpackage

### rtl/ekn_if.sv
// ----------------------------------------------------------------------------
// ekn_if
// Valid/ready channels for knob items and panel results.
// ----------------------------------------------------------------------------
interface ekn_knob_if;
	logic                          valid;
	logic                          ready;
	logic [ekn_pkg::TIME_BITS-1:0] now_ms;
	logic                          mode_pressed;
	logic [1:0]                    enc_step;

	modport source (output valid, output now_ms, output mode_pressed, output enc_step,
		input ready);
	modport sink (input valid, input now_ms, input mode_pressed, input enc_step,
		output ready);
endinterface

interface ekn_panel_if;
	logic       valid;
	logic       ready;
	logic       mode_now;
	logic [7:0] station_sel;
	logic [7:0] volume_sel;
	logic       show_station;
	logic       show_volume;
	logic       disconnect_req;
	logic       connect_req;
	logic       volume_apply;
	logic       led_green;
	logic       led_red;

	modport source (output valid, output mode_now, output station_sel, output volume_sel,
		output show_station, output show_volume, output disconnect_req,
		output connect_req, output volume_apply, output led_green, output led_red,
		input ready);
	modport sink (input valid, input mode_now, input station_sel, input volume_sel,
		input show_station, input show_volume, input disconnect_req,
		input connect_req, input volume_apply, input led_green, input led_red,
		output ready);
endinterface

### rtl/ekn_cfg.sv
// ----------------------------------------------------------------------------
// ekn_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module ekn_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ekn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ekn_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output ekn_pkg::cfg_t                     cfg
);

	ekn_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_hold_ms    <= 16'd1000;
			cfg_q.station_step_ms <= 16'd100;
			cfg_q.volume_step_ms  <= 16'd10;
			cfg_q.settle_ms       <= 16'd700;
			cfg_q.blink_ms        <= 16'd50;
			cfg_q.station_total   <= 9'd15;
			cfg_q.led_mode        <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ekn_pkg::REG_MODE_HOLD:    cfg_q.mode_hold_ms    <= cfg_data;
				ekn_pkg::REG_STATION_STEP: cfg_q.station_step_ms <= cfg_data;
				ekn_pkg::REG_VOLUME_STEP:  cfg_q.volume_step_ms  <= cfg_data;
				ekn_pkg::REG_SETTLE:       cfg_q.settle_ms       <= cfg_data;
				ekn_pkg::REG_BLINK:        cfg_q.blink_ms        <= cfg_data;
				ekn_pkg::REG_STATION_CNT:  cfg_q.station_total   <= cfg_data[8:0];
				ekn_pkg::REG_LED_MODE:     cfg_q.led_mode        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/ekn_core.sv
// ----------------------------------------------------------------------------
// ekn_core
// Knob state and the one-pass update: mode toggle, step, commit, blink, LEDs.
// ----------------------------------------------------------------------------
module ekn_core (
	input  logic           clk,
	input  logic           arst_n,
	input  ekn_pkg::cfg_t  cfg,
	input  ekn_pkg::item_t item,
	input  logic           upd,
	output ekn_pkg::res_t  res
);

	localparam int TB = ekn_pkg::TIME_BITS;

	logic                mode_q;
	logic [7:0]          work_q;
	logic [7:0]          shown_q;
	logic [7:0]          station_q;
	logic [7:0]          volume_q;
	logic [7:0]          comm_st_q;
	logic [7:0]          comm_vol_q;
	logic [TB-1:0]       btn_time_q;
	logic [TB-1:0]       step_time_q;
	logic [TB-1:0]       blink_time_q;
	logic                phase_q;

	logic                mode_n;
	logic [7:0]          work_n;
	logic [7:0]          shown_n;
	logic [7:0]          station_n;
	logic [7:0]          volume_n;
	logic [7:0]          comm_st_n;
	logic [7:0]          comm_vol_n;
	logic [TB-1:0]       btn_time_n;
	logic [TB-1:0]       step_time_n;
	logic [TB-1:0]       blink_time_n;
	logic                phase_n;

	logic [TB-1:0]       el_btn;
	logic [TB-1:0]       el_step;
	logic [TB-1:0]       el_settle;
	logic [TB-1:0]       el_blink;
	logic [15:0]         gap;
	logic [7:0]          top;
	logic [8:0]          stepped;
	logic                sh_st;
	logic                sh_vol;
	logic                disc;
	logic                conn;
	logic                vapply;
	logic                green;
	logic                red;
	logic                is_step;

	always_comb begin
		mode_n       = mode_q;
		work_n       = work_q;
		shown_n      = shown_q;
		station_n    = station_q;
		volume_n     = volume_q;
		comm_st_n    = comm_st_q;
		comm_vol_n   = comm_vol_q;
		btn_time_n   = btn_time_q;
		step_time_n  = step_time_q;
		blink_time_n = blink_time_q;
		phase_n      = phase_q;
		sh_st        = 1'b0;
		sh_vol       = 1'b0;
		disc         = 1'b0;
		conn         = 1'b0;
		vapply       = 1'b0;
		stepped      = 9'd0;

		// mode button
		el_btn = item.now_ms - btn_time_q;
		if (item.mode_pressed && (el_btn > {{(TB-16){1'b0}}, cfg.mode_hold_ms})) begin
			mode_n     = ~mode_q;
			btn_time_n = item.now_ms;
			if (mode_n == ekn_pkg::MODE_STATION) begin
				work_n = station_q;
				sh_st  = 1'b1;
			end else begin
				work_n = volume_q;
				sh_vol = 1'b1;
			end
			shown_n = work_n;
		end

		// upper clamp: station count saturated to 1..256
		if (mode_n == ekn_pkg::MODE_VOLUME) begin
			top = 8'd255;
		end else if (cfg.station_total == 9'd0) begin
			top = 8'd0;
		end else if (cfg.station_total > 9'd256) begin
			top = 8'd255;
		end else begin
			top = 8'(cfg.station_total - 9'd1);
		end

		gap     = (mode_n == ekn_pkg::MODE_STATION) ? cfg.station_step_ms
			: cfg.volume_step_ms;
		is_step = (item.enc_step == ekn_pkg::STEP_INC)
			|| (item.enc_step == ekn_pkg::STEP_DEC);
		el_step = item.now_ms - step_time_q;
		if (is_step && (el_step >= {{(TB-16){1'b0}}, gap})) begin
			if (item.enc_step == ekn_pkg::STEP_INC) begin
				stepped = {1'b0, work_n} + 9'd1;
			end else if (work_n == 8'd0) begin
				stepped = 9'd0;
			end else begin
				stepped = {1'b0, work_n} - 9'd1;
			end
			if (stepped >= {1'b0, top}) begin
				stepped = {1'b0, top};
			end
			work_n = stepped[7:0];
			if (work_n != shown_n) begin
				if (mode_n == ekn_pkg::MODE_STATION) begin
					disc      = 1'b1;
					station_n = work_n;
					sh_st     = 1'b1;
				end else begin
					volume_n = work_n;
					sh_vol   = 1'b1;
				end
				shown_n = work_n;
			end
			step_time_n = item.now_ms;
		end

		// commit after the settle time, measured from the updated step time
		el_settle = item.now_ms - step_time_n;
		if (el_settle >= {{(TB-16){1'b0}}, cfg.settle_ms}) begin
			if (station_n != comm_st_q) begin
				comm_st_n = station_n;
				conn      = 1'b1;
			end
			if (volume_n != comm_vol_q) begin
				comm_vol_n = volume_n;
				vapply     = 1'b1;
			end
		end

		el_blink = item.now_ms - blink_time_q;
		if (el_blink >= {{(TB-16){1'b0}}, cfg.blink_ms}) begin
			phase_n      = ~phase_q;
			blink_time_n = item.now_ms;
		end

		green = 1'b0;
		red   = 1'b0;
		unique case (cfg.led_mode)
			ekn_pkg::LED_GREEN:       green = 1'b1;
			ekn_pkg::LED_RED:         red = 1'b1;
			ekn_pkg::LED_ORANGE: begin
				green = 1'b1;
				red   = 1'b1;
			end
			ekn_pkg::LED_GREEN_BLINK: green = phase_n;
			ekn_pkg::LED_RED_BLINK:   red = phase_n;
			ekn_pkg::LED_ORANGE_BLNK: begin
				green = phase_n;
				red   = phase_n;
			end
			ekn_pkg::LED_G_ON_R_BLNK: begin
				green = 1'b1;
				red   = phase_n;
			end
			ekn_pkg::LED_R_ON_G_BLNK: begin
				green = phase_n;
				red   = 1'b1;
			end
			default: ;
		endcase

		res.mode_now       = mode_n;
		res.station_sel    = station_n;
		res.volume_sel     = volume_n;
		res.show_station   = sh_st;
		res.show_volume    = sh_vol;
		res.disconnect_req = disc;
		res.connect_req    = conn;
		res.volume_apply   = vapply;
		res.led_green      = green;
		res.led_red        = red;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ekn_pkg::MODE_STATION;
			work_q       <= '0;
			shown_q      <= '0;
			station_q    <= '0;
			volume_q     <= '0;
			comm_st_q    <= '0;
			comm_vol_q   <= '0;
			btn_time_q   <= '0;
			step_time_q  <= '0;
			blink_time_q <= '0;
			phase_q      <= 1'b0;
		end else if (upd) begin
			mode_q       <= mode_n;
			work_q       <= work_n;
			shown_q      <= shown_n;
			station_q    <= station_n;
			volume_q     <= volume_n;
			comm_st_q    <= comm_st_n;
			comm_vol_q   <= comm_vol_n;
			btn_time_q   <= btn_time_n;
			step_time_q  <= step_time_n;
			blink_time_q <= blink_time_n;
			phase_q      <= phase_n;
		end
	end

endmodule

### rtl/encoder_knob_selector.sv
// ----------------------------------------------------------------------------
// encoder_knob_selector
// Two-mode front-panel knob controller: station / volume selection.
// ----------------------------------------------------------------------------
// Each knob item is one loop pass (timestamp, button level, encoder step) and
// yields exactly one panel result. An item is registered on input, evaluated
// combinationally against the knob state, and its result is registered on
// output; one item is taken every cycle while the panel output does not
// stall. The input side keeps accepting while a result waits at the output
// as long as the input register is empty.
// Configuration writes take effect on the next cycle and are meant for idle.
module encoder_knob_selector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ekn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ekn_pkg::CFG_DATA_BITS-1:0] cfg_data,
	ekn_knob_if.sink                          knob,
	ekn_panel_if.source                       panel
);

	ekn_pkg::cfg_t  cfg;
	ekn_pkg::item_t item_s1;
	ekn_pkg::res_t  res;
	ekn_pkg::res_t  res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           adv_s1;

	ekn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv_s1     = valid_s1 && (!valid_s2 || panel.ready);
	assign knob.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (knob.ready) begin
			valid_s1 <= knob.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (knob.valid && knob.ready) begin
			item_s1.now_ms       <= knob.now_ms;
			item_s1.mode_pressed <= knob.mode_pressed;
			item_s1.enc_step     <= knob.enc_step;
		end
	end

	ekn_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.upd    (adv_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (panel.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign panel.valid          = valid_s2;
	assign panel.mode_now       = res_s2.mode_now;
	assign panel.station_sel    = res_s2.station_sel;
	assign panel.volume_sel     = res_s2.volume_sel;
	assign panel.show_station   = res_s2.show_station;
	assign panel.show_volume    = res_s2.show_volume;
	assign panel.disconnect_req = res_s2.disconnect_req;
	assign panel.connect_req    = res_s2.connect_req;
	assign panel.volume_apply   = res_s2.volume_apply;
	assign panel.led_green      = res_s2.led_green;
	assign panel.led_red        = res_s2.led_red;

	a_show_st_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(panel.valid && panel.show_station) |-> (panel.mode_now == ekn_pkg::MODE_STATION))
		else $error("station shown outside station mode");

	a_show_vol_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(panel.valid && panel.show_volume) |-> (panel.mode_now == ekn_pkg::MODE_VOLUME))
		else $error("volume shown outside volume mode");

	a_disc_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(panel.valid && panel.disconnect_req) |-> panel.show_station)
		else $error("disconnect without station display");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> knob.ready)
		else $error("input stalled with empty result register");

endmodule

### verif/encoder_knob_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_knob_selector_tb
// Self-checking bench for the two-mode knob controller. Knob items are sent
// in random bursts. Panel results come back under a rotating stall pattern
// and are compared in order with a cycle-free model of the selector. The run
// opens with a directed sequence on the reset settings, then sweeps through
// several panel settings between idle points: all-zero, all-ones, a long
// station climb to the top, a shrink of the station range, and a pass over
// every LED mode.
// ----------------------------------------------------------------------------
module encoder_knob_selector_tb;

	localparam logic [ekn_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] STEP_NONE = 2'd0;
	localparam logic [1:0] STEP_BAD  = 2'd3;
	localparam logic [3:0] LED_OFF   = 4'd0;
	localparam int MAX_REPORTS = 10;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [ekn_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [ekn_pkg::CFG_DATA_BITS-1:0] cfg_data;

	ekn_knob_if  knob ();
	ekn_panel_if panel ();

	encoder_knob_selector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.knob      (knob),
		.panel     (panel)
	);

	// knob model state
	ekn_pkg::cfg_t                 knob_cfg;
	logic                          sel_mode;
	logic [8:0]                    work_val;
	logic [7:0]                    shown_val;
	logic [7:0]                    stn_val;
	logic [7:0]                    vol_val;
	logic [7:0]                    stn_committed;
	logic [7:0]                    vol_committed;
	logic [ekn_pkg::TIME_BITS-1:0] t_button;
	logic [ekn_pkg::TIME_BITS-1:0] t_step;
	logic [ekn_pkg::TIME_BITS-1:0] t_blink;
	logic                          blink_on;

	ekn_pkg::item_t knob_pending [$];
	ekn_pkg::res_t  panel_expected [$];

	ekn_pkg::item_t                nxt_item;
	ekn_pkg::item_t                seen_item;
	ekn_pkg::res_t                 want;
	ekn_pkg::res_t                 oldest;
	ekn_pkg::res_t                 got;
	logic                          item_taken;
	logic [ekn_pkg::TIME_BITS-1:0] clock_ms;
	int                            burst_left;
	int                            gap_left;
	logic [15:0]                   stall_pat;
	int                            stall_age;

	int n_items;
	int n_results;
	int n_errors;
	int n_reports;
	int n_toggles;
	int n_connects;
	int n_applies;
	int n_phases;

	// one loop pass of the selector
	task automatic knob_pass(input ekn_pkg::item_t it, output ekn_pkg::res_t r);
		logic [ekn_pkg::TIME_BITS-1:0] dt;
		logic [15:0]                   gap;
		int                            v;
		int                            top;
		int                            cnt;
		r = '0;
		dt = it.now_ms - t_button;
		if (it.mode_pressed && dt > ekn_pkg::TIME_BITS'(knob_cfg.mode_hold_ms)) begin
			sel_mode = ~sel_mode;
			t_button = it.now_ms;
			n_toggles++;
			if (sel_mode == ekn_pkg::MODE_STATION) begin
				work_val = {1'b0, stn_val};
				r.show_station = 1'b1;
			end else begin
				work_val = {1'b0, vol_val};
				r.show_volume = 1'b1;
			end
			shown_val = work_val[7:0];
		end

		if (it.enc_step == ekn_pkg::STEP_INC || it.enc_step == ekn_pkg::STEP_DEC) begin
			gap = (sel_mode == ekn_pkg::MODE_STATION) ? knob_cfg.station_step_ms
				: knob_cfg.volume_step_ms;
			dt = it.now_ms - t_step;
			if (dt >= ekn_pkg::TIME_BITS'(gap)) begin
				if (sel_mode == ekn_pkg::MODE_STATION) begin
					cnt = int'(knob_cfg.station_total);
					if (cnt < 1)
						cnt = 1;
					if (cnt > 256)
						cnt = 256;
					top = cnt - 1;
				end else begin
					top = 255;
				end
				v = int'(work_val) + ((it.enc_step == ekn_pkg::STEP_INC) ? 1 : -1);
				if (v >= top)
					v = top;
				if (v <= 0)
					v = 0;
				work_val = 9'(v);
				if (work_val != {1'b0, shown_val}) begin
					if (sel_mode == ekn_pkg::MODE_STATION) begin
						r.disconnect_req = 1'b1;
						stn_val = work_val[7:0];
						r.show_station = 1'b1;
					end else begin
						vol_val = work_val[7:0];
						r.show_volume = 1'b1;
					end
					shown_val = work_val[7:0];
				end
				t_step = it.now_ms;
			end
		end

		// commit runs after the step in the same pass
		dt = it.now_ms - t_step;
		if (dt >= ekn_pkg::TIME_BITS'(knob_cfg.settle_ms)) begin
			if (stn_val != stn_committed) begin
				stn_committed = stn_val;
				r.connect_req = 1'b1;
				n_connects++;
			end
			if (vol_val != vol_committed) begin
				vol_committed = vol_val;
				r.volume_apply = 1'b1;
				n_applies++;
			end
		end

		dt = it.now_ms - t_blink;
		if (dt >= ekn_pkg::TIME_BITS'(knob_cfg.blink_ms)) begin
			blink_on = ~blink_on;
			t_blink = it.now_ms;
		end

		case (knob_cfg.led_mode)
			ekn_pkg::LED_GREEN: r.led_green = 1'b1;
			ekn_pkg::LED_RED: r.led_red = 1'b1;
			ekn_pkg::LED_ORANGE: begin
				r.led_green = 1'b1;
				r.led_red = 1'b1;
			end
			ekn_pkg::LED_GREEN_BLINK: r.led_green = blink_on;
			ekn_pkg::LED_RED_BLINK: r.led_red = blink_on;
			ekn_pkg::LED_ORANGE_BLNK: begin
				r.led_green = blink_on;
				r.led_red = blink_on;
			end
			ekn_pkg::LED_G_ON_R_BLNK: begin
				r.led_green = 1'b1;
				r.led_red = blink_on;
			end
			ekn_pkg::LED_R_ON_G_BLNK: begin
				r.led_green = blink_on;
				r.led_red = 1'b1;
			end
			default: ;
		endcase

		r.mode_now = sel_mode;
		r.station_sel = stn_val;
		r.volume_sel = vol_val;
	endtask

	function automatic string panel_str(input ekn_pkg::res_t r);
		return $sformatf({"mode=%0d stn=%0d vol=%0d show_s=%b show_v=%b ",
			"disc=%b conn=%b apply=%b g=%b r=%b"},
			r.mode_now, r.station_sel, r.volume_sel, r.show_station, r.show_volume,
			r.disconnect_req, r.connect_req, r.volume_apply, r.led_green, r.led_red);
	endfunction

	task automatic write_reg(input logic [ekn_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [ekn_pkg::CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			ekn_pkg::REG_MODE_HOLD: knob_cfg.mode_hold_ms = val;
			ekn_pkg::REG_STATION_STEP: knob_cfg.station_step_ms = val;
			ekn_pkg::REG_VOLUME_STEP: knob_cfg.volume_step_ms = val;
			ekn_pkg::REG_SETTLE: knob_cfg.settle_ms = val;
			ekn_pkg::REG_BLINK: knob_cfg.blink_ms = val;
			ekn_pkg::REG_STATION_CNT: knob_cfg.station_total = val[8:0];
			ekn_pkg::REG_LED_MODE: knob_cfg.led_mode = val[3:0];
			default: ;
		endcase
	endtask

	task automatic set_panel_cfg(input logic [15:0] hold, input logic [15:0] sstep,
		input logic [15:0] vstep, input logic [15:0] settle, input logic [15:0] blink,
		input logic [15:0] cnt, input logic [15:0] led);
		write_reg(ekn_pkg::REG_MODE_HOLD, hold);
		write_reg(ekn_pkg::REG_STATION_STEP, sstep);
		write_reg(ekn_pkg::REG_VOLUME_STEP, vstep);
		write_reg(ekn_pkg::REG_SETTLE, settle);
		write_reg(ekn_pkg::REG_BLINK, blink);
		write_reg(ekn_pkg::REG_STATION_CNT, cnt);
		write_reg(ekn_pkg::REG_LED_MODE, led);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		n_phases++;
	endtask

	task automatic add_item(input logic [ekn_pkg::TIME_BITS-1:0] t, input logic p,
		input logic [1:0] s);
		ekn_pkg::item_t it;
		it.now_ms = t;
		it.mode_pressed = p;
		it.enc_step = s;
		clock_ms = t;
		knob_pending.push_back(it);
	endtask

	task automatic queue_random(input int n, input int press_pct, input int inc_pct);
		int                            pick;
		logic [ekn_pkg::TIME_BITS-1:0] dt;
		logic [1:0]                    s;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				dt = $urandom_range(0, 30);
			else if (pick < 70)
				dt = $urandom_range(0, 300);
			else if (pick < 90)
				dt = $urandom_range(0, 2000);
			else if (pick < 97)
				dt = $urandom_range(0, 70000);
			else
				dt = $urandom;
			if ($urandom_range(0, 99) < inc_pct) begin
				s = ekn_pkg::STEP_INC;
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 8)
					s = STEP_NONE;
				else if (pick < 17)
					s = ekn_pkg::STEP_DEC;
				else
					s = STEP_BAD;
			end
			add_item(clock_ms + dt, $urandom_range(0, 99) < press_pct, s);
		end
	endtask

	task automatic wait_idle();
		while (knob_pending.size() != 0 || knob.valid || panel_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// item driver and result stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			if (!knob.valid || item_taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					knob.valid <= 1'b0;
				end else if (knob_pending.size() > 0) begin
					nxt_item = knob_pending.pop_front();
					knob.valid <= 1'b1;
					knob.now_ms <= nxt_item.now_ms;
					knob.mode_pressed <= nxt_item.mode_pressed;
					knob.enc_step <= nxt_item.enc_step;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
							: $urandom_range(1, 8);
						gap_left <= $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					knob.valid <= 1'b0;
				end
			end
			if (stall_age == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pat <= '1;
					1: stall_pat <= 16'($urandom);
					2: stall_pat <= 16'($urandom | $urandom);
					default: stall_pat <= 16'($urandom & $urandom);
				endcase
				stall_age <= $urandom_range(16, 64);
			end else begin
				stall_pat <= {stall_pat[14:0], stall_pat[15]};
				stall_age <= stall_age - 1;
			end
			panel.ready <= stall_pat[0];
		end
	end

	// monitor: predict on every accepted item, check every accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= knob.valid && knob.ready;
			if (knob.valid && knob.ready) begin
				seen_item.now_ms = knob.now_ms;
				seen_item.mode_pressed = knob.mode_pressed;
				seen_item.enc_step = knob.enc_step;
				knob_pass(seen_item, want);
				panel_expected.push_back(want);
				n_items++;
			end
			if (panel.valid && panel.ready) begin
				got.mode_now = panel.mode_now;
				got.station_sel = panel.station_sel;
				got.volume_sel = panel.volume_sel;
				got.show_station = panel.show_station;
				got.show_volume = panel.show_volume;
				got.disconnect_req = panel.disconnect_req;
				got.connect_req = panel.connect_req;
				got.volume_apply = panel.volume_apply;
				got.led_green = panel.led_green;
				got.led_red = panel.led_red;
				n_results++;
				if (panel_expected.size() == 0) begin
					n_errors++;
					if (n_reports < MAX_REPORTS) begin
						n_reports++;
						$display("ERROR: unexpected result %s", panel_str(got));
					end
				end else begin
					oldest = panel_expected.pop_front();
					if (got !== oldest) begin
						n_errors++;
						if (n_reports < MAX_REPORTS) begin
							n_reports++;
							$display("ERROR: result %0d mismatch", n_results);
							$display("  want %s", panel_str(oldest));
							$display("  got  %s", panel_str(got));
						end
					end
				end
			end
		end
	end

	initial begin
		logic [3:0] led;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		knob.valid = 1'b0;
		knob.now_ms = '0;
		knob.mode_pressed = 1'b0;
		knob.enc_step = STEP_NONE;
		panel.ready = 1'b0;
		item_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_pat = '1;
		stall_age = 0;
		clock_ms = '0;
		n_items = 0;
		n_results = 0;
		n_errors = 0;
		n_reports = 0;
		n_toggles = 0;
		n_connects = 0;
		n_applies = 0;
		n_phases = 1;

		knob_cfg.mode_hold_ms = 16'd1000;
		knob_cfg.station_step_ms = 16'd100;
		knob_cfg.volume_step_ms = 16'd10;
		knob_cfg.settle_ms = 16'd700;
		knob_cfg.blink_ms = 16'd50;
		knob_cfg.station_total = 9'd15;
		knob_cfg.led_mode = LED_OFF;
		sel_mode = ekn_pkg::MODE_STATION;
		work_val = '0;
		shown_val = '0;
		stn_val = '0;
		vol_val = '0;
		stn_committed = '0;
		vol_committed = '0;
		t_button = '0;
		t_step = '0;
		t_blink = '0;
		blink_on = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: hold boundary, bad step code, clamps, wrap, commits
		add_item(32'd0, 1'b1, STEP_NONE);
		add_item(32'd0, 1'b0, STEP_BAD);
		add_item(32'd1000, 1'b1, STEP_NONE);
		add_item(32'd1001, 1'b1, ekn_pkg::STEP_DEC);
		add_item(32'd1005, 1'b0, ekn_pkg::STEP_INC);
		add_item(32'd1011, 1'b0, ekn_pkg::STEP_INC);
		add_item(32'd1021, 1'b0, ekn_pkg::STEP_INC);
		add_item(32'd1800, 1'b0, STEP_NONE);
		add_item(32'hFFFF_FF00, 1'b1, ekn_pkg::STEP_INC);
		add_item(32'hFFFF_FFFF, 1'b0, ekn_pkg::STEP_INC);
		add_item(32'h0000_0064, 1'b0, ekn_pkg::STEP_INC);
		add_item(32'h0000_00C8, 1'b1, ekn_pkg::STEP_INC);
		repeat (12)
			add_item(clock_ms + 32'd100, 1'b0, ekn_pkg::STEP_INC);
		add_item(clock_ms + 32'd700, 1'b0, STEP_NONE);
		wait_idle();

		// all-zero settings, station count zero, plus a write to a missing index
		write_reg(REG_UNUSED, '1);
		set_panel_cfg('0, '0, '0, '0, '0, '0, 16'(ekn_pkg::LED_GREEN_BLINK));
		queue_random(40, 30, 30);
		wait_idle();

		// all-ones: count and LED mode saturate from the mask
		set_panel_cfg('1, '1, '1, '1, '1, '1, '1);
		queue_random(30, 30, 30);
		wait_idle();

		// long climb in station mode toward the top station
		set_panel_cfg(16'd200, 16'd0, 16'd0, 16'd300, 16'd20, 16'd256,
			16'(ekn_pkg::LED_ORANGE_BLNK));
		if (sel_mode == ekn_pkg::MODE_VOLUME)
			add_item(t_button + 32'd1000, 1'b1, STEP_NONE);
		queue_random(280, 0, 97);
		wait_idle();

		// shrink the range under a high station; next step clamps it
		set_panel_cfg(16'd100, 16'd50, 16'd5, 16'd150, 16'd7, 16'd5,
			16'(ekn_pkg::LED_R_ON_G_BLNK));
		add_item(t_step + 32'd60, 1'b0, ekn_pkg::STEP_DEC);
		queue_random(40, 25, 45);
		wait_idle();

		for (led = LED_OFF; led <= ekn_pkg::LED_R_ON_G_BLNK; led++) begin
			set_panel_cfg(16'($urandom_range(0, 400)), 16'($urandom_range(0, 120)),
				16'($urandom_range(0, 40)), 16'($urandom_range(0, 800)),
				16'($urandom_range(0, 100)),
				led[0] ? 16'($urandom_range(0, 511)) : 16'($urandom_range(1, 20)),
				16'(led));
			queue_random(10, 20, 35);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (panel_expected.size() != 0)
			n_errors += panel_expected.size();
		$display("Ran %0d knob items under %0d panel settings; %0d results checked, %0d errors.",
			n_items, n_phases, n_results, n_errors);
		$display("Model saw %0d mode toggles, %0d station connects, %0d volume applies.",
			n_toggles, n_connects, n_applies);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout with %0d results outstanding.", panel_expected.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
